// ===== hdl/ccfp_pkg.sv =====
// shared types and constants for the command frame parser
// used by every module of the parser; no dependencies
package ccfp_pkg;

  // frame framing bytes
  localparam logic [7:0] HEADER_BYTE = 8'hAB;
  localparam logic [7:0] ACK_SYNC    = 8'hAA;
  localparam logic [7:0] ACK_TAG     = 8'hEF;
  localparam logic [7:0] ACK_LEN     = 8'h02;
  localparam logic [7:0] FUNC_IDLE   = 8'hFF;

  // sum of the four fixed leading ack bytes, mod 256
  localparam logic [7:0] ACK_PREFIX_SUM = 8'(ACK_SYNC + ACK_SYNC + ACK_TAG + ACK_LEN);

  // default payload limit
  localparam int MAX_PAYLOAD_DEF = 49;

  // frame status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SUM = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // configuration register indexes
  localparam logic [7:0] REG_X_MOVE    = 8'd0;
  localparam logic [7:0] REG_Y_MOVE    = 8'd1;
  localparam logic [7:0] REG_YAW_MOVE  = 8'd2;
  localparam logic [7:0] REG_SERVO_SET = 8'd3;

  // frame queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // number of payload bytes kept per frame
  localparam int HEAD_BYTES = 6;

  // acknowledged function codes
  typedef struct packed {
    logic [7:0] x_move;
    logic [7:0] y_move;
    logic [7:0] yaw_move;
    logic [7:0] servo_set;
  } codes_t;

  // one finished frame handed from front to back
  typedef struct packed {
    logic [1:0]                 status;
    logic [7:0]                 func;
    logic [HEAD_BYTES-1:0][7:0] head;
    logic [7:0]                 sum;
    logic                       ack;
  } frame_evt_t;

endpackage

// ===== hdl/ccfp_front.sv =====
// front end: byte-level frame parser, builds one frame record per checksum byte
// depends on ccfp_pkg
module ccfp_front #(
  parameter int MAX_PAYLOAD = ccfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  input  ccfp_pkg::codes_t     codes,
  input  logic                 q_full,
  output logic                 evt_push,
  output ccfp_pkg::frame_evt_t evt
);
  import ccfp_pkg::*;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_FUNC = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  logic [1:0]                 phase, phase_next;
  logic [7:0]                 func_held, func_held_next;
  logic [7:0]                 length_held, length_held_next;
  logic [7:0]                 bytes_seen, bytes_seen_next;
  logic [7:0]                 running_sum, running_sum_next;
  logic [HEAD_BYTES-1:0][7:0] head, head_next;
  logic                       in_fire;
  logic                       code_hit;
  logic [1:0]                 status;

  // stall only when the frame queue has no room
  assign in_stall = q_full;
  assign in_fire  = in_valid && !q_full;

  // checksum status and ack decision for the frame ending with this byte
  always_comb begin
    if (length_held > 8'(MAX_PAYLOAD)) status = ST_TOO_LONG;
    else if (rx_byte != running_sum) status = ST_BAD_SUM;
    else status = ST_OK;
    code_hit = (func_held == codes.x_move) || (func_held == codes.y_move) ||
               (func_held == codes.yaw_move) || (func_held == codes.servo_set);
  end

  // parser next state
  always_comb begin
    phase_next       = phase;
    func_held_next   = func_held;
    length_held_next = length_held;
    bytes_seen_next  = bytes_seen;
    running_sum_next = running_sum;
    head_next        = head;
    evt_push         = 1'b0;
    evt.status       = status;
    evt.func         = func_held;
    evt.head         = head;
    evt.sum          = running_sum;
    evt.ack          = (status == ST_OK) && code_hit;
    if (in_fire) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == HEADER_BYTE) begin
            running_sum_next = HEADER_BYTE;
            head_next        = '0;
            phase_next       = PH_FUNC;
          end
        end
        PH_FUNC: begin
          func_held_next   = rx_byte;
          running_sum_next = 8'(running_sum + rx_byte);
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          length_held_next = rx_byte;
          bytes_seen_next  = 8'd0;
          running_sum_next = 8'(running_sum + rx_byte);
          phase_next       = PH_BODY;
        end
        PH_BODY: begin
          if (bytes_seen != length_held) begin
            for (int i = 0; i < HEAD_BYTES; i++) begin
              if (bytes_seen == 8'(i)) head_next[i] = rx_byte;
            end
            bytes_seen_next  = 8'(bytes_seen + 8'd1);
            running_sum_next = 8'(running_sum + rx_byte);
          end else begin
            // checksum byte closes the frame
            evt_push         = 1'b1;
            phase_next       = PH_HUNT;
            func_held_next   = FUNC_IDLE;
            length_held_next = 8'd0;
            bytes_seen_next  = 8'd0;
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      func_held   <= FUNC_IDLE;
      length_held <= 8'd0;
      bytes_seen  <= 8'd0;
      running_sum <= 8'd0;
    end else begin
      phase       <= phase_next;
      func_held   <= func_held_next;
      length_held <= length_held_next;
      bytes_seen  <= bytes_seen_next;
      running_sum <= running_sum_next;
    end
  end

  // payload head bytes, cleared at each header
  always_ff @(posedge clk) begin
    head <= head_next;
  end

  // frame closes only in the body phase with all payload seen
  a_push_at_end: assert property (@(posedge clk) disable iff (rst)
    evt_push |-> (phase == PH_BODY) && (bytes_seen == length_held))
    else $error("frame pushed outside checksum byte");

  // after the checksum byte the parser hunts again
  a_back_to_hunt: assert property (@(posedge clk) disable iff (rst)
    evt_push |=> (phase == PH_HUNT) && (bytes_seen == 8'd0))
    else $error("parser did not return to hunt");

  // payload count never passes the frame length
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (bytes_seen <= length_held))
    else $error("payload count beyond length");

endmodule

// ===== hdl/ccfp_queue.sv =====
// small queue of finished frame records between front and back
// depends on ccfp_pkg
module ccfp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ccfp_pkg::frame_evt_t wr_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output ccfp_pkg::frame_evt_t rd_data
);
  import ccfp_pkg::*;

  frame_evt_t      mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign full      = (count == Q_CW'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== hdl/ccfp_back.sv =====
// back end: emits the frame result item and, for acknowledged frames, the acknowledge bytes
// depends on ccfp_pkg
module ccfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  ccfp_pkg::frame_evt_t q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 is_ack_byte,
  output logic [1:0]           frame_status,
  output logic [7:0]           function_code,
  output logic signed [15:0]   word_first,
  output logic signed [15:0]   word_second,
  output logic signed [15:0]   word_third,
  output logic [7:0]           sub_select,
  output logic signed [15:0]   servo_value,
  output logic [7:0]           ack_data,
  output logic                 last_of_run
);
  import ccfp_pkg::*;

  localparam logic [2:0] STEP_RESULT = 3'd0;
  localparam logic [2:0] STEP_SYNC0  = 3'd1;
  localparam logic [2:0] STEP_SYNC1  = 3'd2;
  localparam logic [2:0] STEP_TAG    = 3'd3;
  localparam logic [2:0] STEP_LEN    = 3'd4;
  localparam logic [2:0] STEP_FUNC   = 3'd5;
  localparam logic [2:0] STEP_SUM    = 3'd6;
  localparam logic [2:0] STEP_CHK    = 3'd7;

  frame_evt_t evt;
  logic       busy;
  logic [2:0] step;
  logic       out_fire;
  logic       last_beat;

  assign out_valid = busy;
  assign out_fire  = busy && !out_stall;
  assign last_beat = ((step == STEP_RESULT) && !evt.ack) || (step == STEP_CHK);
  assign q_pop     = q_not_empty && (!busy || (out_fire && last_beat));

  // working frame and beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_RESULT;
    end else if (q_pop) begin
      busy <= 1'b1;
      step <= STEP_RESULT;
    end else if (out_fire) begin
      if (last_beat) busy <= 1'b0;
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) evt <= q_data;
  end

  // output fields per beat
  always_comb begin
    is_ack_byte   = 1'b1;
    frame_status  = ST_OK;
    function_code = 8'd0;
    word_first    = 16'sd0;
    word_second   = 16'sd0;
    word_third    = 16'sd0;
    sub_select    = 8'd0;
    servo_value   = 16'sd0;
    ack_data      = 8'd0;
    last_of_run   = last_beat;
    case (step)
      STEP_RESULT: begin
        is_ack_byte   = 1'b0;
        frame_status  = evt.status;
        function_code = evt.func;
        word_first    = signed'({evt.head[0], evt.head[1]});
        word_second   = signed'({evt.head[2], evt.head[3]});
        word_third    = signed'({evt.head[4], evt.head[5]});
        sub_select    = evt.head[0];
        servo_value   = signed'({evt.head[1], evt.head[2]});
      end
      STEP_SYNC0: ack_data = ACK_SYNC;
      STEP_SYNC1: ack_data = ACK_SYNC;
      STEP_TAG:   ack_data = ACK_TAG;
      STEP_LEN:   ack_data = ACK_LEN;
      STEP_FUNC:  ack_data = evt.func;
      STEP_SUM:   ack_data = evt.sum;
      STEP_CHK:   ack_data = 8'(ACK_PREFIX_SUM + evt.func + evt.sum);
      default:    ack_data = 8'd0;
    endcase
  end

  // ack beats only follow an ok frame with a matching code
  a_ack_only_ok: assert property (@(posedge clk) disable iff (rst)
    (busy && (step != STEP_RESULT)) |-> (evt.ack && (evt.status == ST_OK)))
    else $error("ack byte for a frame that is not acknowledged");

  // a stalled beat keeps its place
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (busy && out_stall) |=> busy && $stable(step))
    else $error("beat lost under stall");

  // no new frame is loaded while a beat is still pending
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!busy || (out_fire && last_beat)))
    else $error("frame loaded over a pending beat");

endmodule

// ===== hdl/checksummed_command_frame_parser_unit.sv =====
// A frame record is queued as its checksum byte is accepted, then loaded into the back
// end before its result item is offered. Throughput: one received byte per cycle,
// stalled only while the 4-entry frame queue is full. Per frame the back end offers a
// result item, plus acknowledge bytes if acknowledged. Reset is synchronous: the parser
// hunts for a header and the function code registers return to 1, 2, 3 and 4.
module checksummed_command_frame_parser_unit #(
  parameter int MAX_PAYLOAD = ccfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                is_ack_byte,
  output logic [1:0]          frame_status,
  output logic [7:0]          function_code,
  output logic signed [15:0]  word_first,
  output logic signed [15:0]  word_second,
  output logic signed [15:0]  word_third,
  output logic [7:0]          sub_select,
  output logic signed [15:0]  servo_value,
  output logic [7:0]          ack_data,
  output logic                last_of_run,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import ccfp_pkg::*;

  codes_t     codes;
  logic       q_full;
  logic       q_not_empty;
  logic       q_push;
  logic       q_pop;
  frame_evt_t evt_in;
  frame_evt_t evt_out;

  assign cfg_ready = 1'b1;

  // function code registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      codes.x_move    <= 8'd1;
      codes.y_move    <= 8'd2;
      codes.yaw_move  <= 8'd3;
      codes.servo_set <= 8'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_MOVE:    codes.x_move    <= cfg_data;
        REG_Y_MOVE:    codes.y_move    <= cfg_data;
        REG_YAW_MOVE:  codes.yaw_move  <= cfg_data;
        REG_SERVO_SET: codes.servo_set <= cfg_data;
        default: ;
      endcase
    end
  end

  ccfp_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .codes    (codes),
    .q_full   (q_full),
    .evt_push (q_push),
    .evt      (evt_in)
  );

  ccfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (evt_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_data   (evt_out)
  );

  ccfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_data        (evt_out),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_ack_byte   (is_ack_byte),
    .frame_status  (frame_status),
    .function_code (function_code),
    .word_first    (word_first),
    .word_second   (word_second),
    .word_third    (word_third),
    .sub_select    (sub_select),
    .servo_value   (servo_value),
    .ack_data      (ack_data),
    .last_of_run   (last_of_run)
  );

endmodule

// ===== tb/tb_checksummed_command_frame_parser_unit.sv =====
// self-checking testbench for the checksummed command frame parser unit
// depends on ccfp_pkg and checksummed_command_frame_parser_unit; runs a directed
// table of frames, then random frame traffic under three idle patterns and code sets
module tb_checksummed_command_frame_parser_unit;
  import ccfp_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_TIME = 3_000_000;
  localparam int NO_CHECK = -1;
  localparam int ROW_COUNT = 10;
  // register indexes that address nothing
  localparam logic [7:0] REG_UNUSED_LOW = 8'd4;
  localparam logic [7:0] REG_UNUSED_MID = 8'hC3;
  localparam logic [7:0] REG_UNUSED_TOP = 8'hFF;

  typedef enum logic [1:0] {HUNT, GET_FUNC, GET_LEN, GET_BODY} parse_state_t;

  // one result item as seen on the output port
  typedef struct {
    logic               is_ack;
    logic [1:0]         status;
    logic [7:0]         func;
    logic signed [15:0] w_first;
    logic signed [15:0] w_second;
    logic signed [15:0] w_third;
    logic [7:0]         sub;
    logic signed [15:0] servo;
    logic [7:0]         ack;
    logic               last;
  } frame_item_t;

  // one directed frame: leading noise, frame contents, checksum offset, typed status
  typedef struct {
    int          lead;
    logic [7:0]  noise;
    logic [7:0]  func;
    int          len;
    logic [47:0] head;
    logic [7:0]  fill;
    logic [7:0]  delta;
    int          want_status;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_ack_byte;
  logic [1:0] frame_status;
  logic [7:0] function_code;
  logic signed [15:0] word_first;
  logic signed [15:0] word_second;
  logic signed [15:0] word_third;
  logic [7:0] sub_select;
  logic signed [15:0] servo_value;
  logic [7:0] ack_data;
  logic last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = 8'h00;
  logic [7:0] cfg_data = 8'h00;

  checksummed_command_frame_parser_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_ack_byte(is_ack_byte), .frame_status(frame_status),
    .function_code(function_code), .word_first(word_first),
    .word_second(word_second), .word_third(word_third),
    .sub_select(sub_select), .servo_value(servo_value),
    .ack_data(ack_data), .last_of_run(last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // parser shadow state and acknowledged codes
  parse_state_t pstate = HUNT;
  logic [7:0] func_reg = FUNC_IDLE;
  logic [7:0] body_len = 8'h00;
  logic [7:0] body_count = 8'h00;
  logic [7:0] run_sum = 8'h00;
  logic [7:0] head_bytes [HEAD_BYTES];
  codes_t ack_codes = '{x_move: 8'd1, y_move: 8'd2, yaw_move: 8'd3, servo_set: 8'd4};
  int last_status = NO_CHECK;

  frame_item_t pending_items [$];
  frame_item_t got;
  frame_item_t want;
  frame_row_t dir_rows [ROW_COUNT];
  bit failed = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #LIMIT_TIME;
    $display("tb_checksummed_command_frame_parser_unit NOT OK");
    $finish;
  end

  // shadow parser: consumes one accepted byte, queues the items it causes
  task automatic predict_byte(input logic [7:0] b);
    frame_item_t r;
    logic [7:0] seq [7];
    logic hit;
    int i;
    case (pstate)
      HUNT: begin
        if (b == HEADER_BYTE) begin
          run_sum = HEADER_BYTE;
          for (i = 0; i < HEAD_BYTES; i++) head_bytes[i] = 8'h00;
          pstate = GET_FUNC;
        end
      end
      GET_FUNC: begin
        func_reg = b;
        run_sum = run_sum + b;
        pstate = GET_LEN;
      end
      GET_LEN: begin
        body_len = b;
        body_count = 8'h00;
        run_sum = run_sum + b;
        pstate = GET_BODY;
      end
      default: begin
        if (body_count != body_len) begin
          if (body_count < HEAD_BYTES) head_bytes[body_count] = b;
          body_count = body_count + 8'd1;
          run_sum = run_sum + b;
        end else begin
          r = '{default: '0};
          if (body_len > MAX_PAYLOAD_DEF) r.status = ST_TOO_LONG;
          else if (b != run_sum) r.status = ST_BAD_SUM;
          else r.status = ST_OK;
          r.func = func_reg;
          r.w_first = {head_bytes[0], head_bytes[1]};
          r.w_second = {head_bytes[2], head_bytes[3]};
          r.w_third = {head_bytes[4], head_bytes[5]};
          r.sub = head_bytes[0];
          r.servo = {head_bytes[1], head_bytes[2]};
          hit = (r.status == ST_OK) &&
                (func_reg == ack_codes.x_move || func_reg == ack_codes.y_move ||
                 func_reg == ack_codes.yaw_move || func_reg == ack_codes.servo_set);
          r.last = !hit;
          pending_items.push_back(r);
          last_status = r.status;
          if (hit) begin
            seq[0] = ACK_SYNC;
            seq[1] = ACK_SYNC;
            seq[2] = ACK_TAG;
            seq[3] = ACK_LEN;
            seq[4] = func_reg;
            seq[5] = run_sum;
            seq[6] = 8'h00;
            for (i = 0; i < 6; i++) seq[6] = seq[6] + seq[i];
            for (i = 0; i < 7; i++) begin
              r = '{default: '0};
              r.is_ack = 1'b1;
              r.ack = seq[i];
              r.last = (i == 6);
              pending_items.push_back(r);
            end
          end
          pstate = HUNT;
          func_reg = FUNC_IDLE;
          body_len = 8'h00;
          body_count = 8'h00;
        end
      end
    endcase
  endtask

  // offer one byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b);
  endtask

  // header, function, length, body and checksum; delta spoils the checksum
  task automatic send_frame(input logic [7:0] func, input int len, input logic [47:0] head,
                            input logic [7:0] fill, input bit rand_body,
                            input logic [7:0] delta);
    logic [7:0] sum;
    logic [7:0] pb;
    int i;
    sum = HEADER_BYTE + func + 8'(len);
    send_byte(HEADER_BYTE);
    send_byte(func);
    send_byte(8'(len));
    for (i = 0; i < len; i++) begin
      if (i < HEAD_BYTES) pb = head[47 - 8 * i -: 8];
      else if (rand_body) pb = 8'($urandom_range(255));
      else pb = fill;
      sum = sum + pb;
      send_byte(pb);
    end
    send_byte(sum + delta);
  endtask

  // random traffic: mostly well formed frames, some noise and spoiled checksums
  task automatic run_random(input int budget);
    int frame_bytes;
    int pick;
    int len;
    int i;
    logic [7:0] func;
    logic [7:0] delta;
    frame_bytes = 0;
    while (frame_bytes < budget) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        for (i = 0; i < $urandom_range(1, 4); i++) send_byte(8'($urandom_range(255)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          case ($urandom_range(3))
            0: func = ack_codes.x_move;
            1: func = ack_codes.y_move;
            2: func = ack_codes.yaw_move;
            default: func = ack_codes.servo_set;
          endcase
        end else if (pick < 60) begin
          func = FUNC_IDLE;
        end else begin
          func = 8'($urandom_range(255));
        end
        pick = $urandom_range(99);
        if (pick < 80) len = $urandom_range(0, 8);
        else if (pick < 95) len = $urandom_range(9, MAX_PAYLOAD_DEF);
        else len = $urandom_range(MAX_PAYLOAD_DEF + 1, 255);
        delta = ($urandom_range(99) < 80) ? 8'h00 : 8'($urandom_range(1, 255));
        send_frame(func, len, {32'($urandom), 16'($urandom)}, 8'h00, 1'b1, delta);
        frame_bytes += len + 4;
      end
    end
    // finish any frame that noise may have opened
    while (pstate != HUNT) send_byte(8'($urandom_range(255)));
  endtask

  // stop sending and let every queued item come out
  task automatic settle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write a batch of registers back to back, valid held high through the batch
  task automatic write_regs(input logic [7:0] idx [], input logic [7:0] val []);
    int i;
    for (i = 0; i < idx.size(); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        REG_X_MOVE: ack_codes.x_move = val[i];
        REG_Y_MOVE: ack_codes.y_move = val[i];
        REG_YAW_MOVE: ack_codes.yaw_move = val[i];
        REG_SERVO_SET: ack_codes.servo_set = val[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string fname, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      failed = 1'b1;
      $display("%0t %s expected %h actual %h", $time, fname, exp_v, act_v);
    end
  endtask

  // output side: compare each accepted item with the oldest expectation
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      got = '{is_ack_byte, frame_status, function_code, word_first, word_second,
              word_third, sub_select, servo_value, ack_data, last_of_run};
      if (pending_items.size() == 0) begin
        failed = 1'b1;
        $display("%0t unexpected item expected none actual ack %b status %h func %h data %h",
                 $time, is_ack_byte, frame_status, function_code, ack_data);
      end else begin
        want = pending_items.pop_front();
        check_field("is_ack_byte", 16'(want.is_ack), 16'(got.is_ack));
        check_field("frame_status", 16'(want.status), 16'(got.status));
        check_field("function_code", 16'(want.func), 16'(got.func));
        check_field("word_first", want.w_first, got.w_first);
        check_field("word_second", want.w_second, got.w_second);
        check_field("word_third", want.w_third, got.w_third);
        check_field("sub_select", 16'(want.sub), 16'(got.sub));
        check_field("servo_value", want.servo, got.servo);
        check_field("ack_data", 16'(want.ack), 16'(got.ack));
        check_field("last_of_run", 16'(want.last), 16'(got.last));
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // directed frames, statuses typed in where they are plain
  task automatic load_rows;
    // acknowledged x move with signed extremes in the words, right after reset
    dir_rows[0] = '{2, 8'h00, 8'd1, 6, 48'h8000_7FFF_0001, 8'h00, 8'h00, ST_OK};
    // no payload: every word reads as zero
    dir_rows[1] = '{0, 8'h00, 8'd2, 0, 48'h0, 8'h00, 8'h00, ST_OK};
    // short payload of all ones with a spoiled checksum
    dir_rows[2] = '{1, 8'hFF, 8'd3, 3, 48'hFFFF_FF00_0000, 8'h00, 8'h01, ST_BAD_SUM};
    // header byte inside the payload is plain data
    dir_rows[3] = '{0, 8'h00, 8'd4, 7, 48'hABAB_12AB_3456, 8'hAB, 8'h00, ST_OK};
    // valid frame whose code is not acknowledged
    dir_rows[4] = '{0, 8'h00, 8'h55, 2, 48'h7F80_0000_0000, 8'h00, 8'h00, NO_CHECK};
    // longest payload that is still accepted
    dir_rows[5] = '{0, 8'h00, FUNC_IDLE, MAX_PAYLOAD_DEF, 48'hFFFF_FFFF_FFFF, 8'hFF,
                    8'h00, ST_OK};
    // one byte too long: flagged even with a good checksum
    dir_rows[6] = '{0, 8'h00, 8'd1, MAX_PAYLOAD_DEF + 1, 48'h0102_0304_0506, 8'h5A,
                    8'h00, ST_TOO_LONG};
    // function code zero with checksum off by all ones
    dir_rows[7] = '{0, 8'h00, 8'h00, 5, 48'h0000_0000_0000, 8'h00, 8'hFF, ST_BAD_SUM};
    // header value as function code
    dir_rows[8] = '{0, 8'h00, HEADER_BYTE, 6, 48'h0000_0000_0000, 8'h00, 8'h00, NO_CHECK};
    // noise ahead of a one byte payload
    dir_rows[9] = '{3, 8'h7E, 8'd3, 1, 48'hC300_0000_0000, 8'h00, 8'h00, NO_CHECK};
  endtask

  // main sequence
  initial begin
    int r;
    int k;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver mostly stalled; reset codes in use
    send_idle_pct = 14;
    recv_stall_pct = 85;
    load_rows();
    for (r = 0; r < ROW_COUNT; r++) begin
      for (k = 0; k < dir_rows[r].lead; k++) send_byte(dir_rows[r].noise);
      send_frame(dir_rows[r].func, dir_rows[r].len, dir_rows[r].head, dir_rows[r].fill,
                 1'b0, dir_rows[r].delta);
      if (dir_rows[r].want_status != NO_CHECK && last_status != dir_rows[r].want_status) begin
        failed = 1'b1;
        $display("%0t row %0d status expected %0d actual %0d", $time, r,
                 dir_rows[r].want_status, last_status);
      end
    end
    run_random(15);
    settle();

    // extremes and duplicate codes; writes to unused indexes are dropped
    write_regs('{REG_X_MOVE, REG_Y_MOVE, REG_YAW_MOVE, REG_SERVO_SET, REG_UNUSED_LOW,
                 REG_UNUSED_TOP},
               '{8'h00, 8'hFF, 8'h00, 8'h80, 8'h09, 8'h55});
    send_idle_pct = 85;
    recv_stall_pct = 14;
    run_random(15);
    settle();

    // top code duplicated, no idling on either side
    write_regs('{REG_X_MOVE, REG_Y_MOVE, REG_YAW_MOVE, REG_SERVO_SET, REG_UNUSED_MID},
               '{8'hFF, 8'hFF, 8'h7F, 8'h01, 8'h02});
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(15);
    settle();

    if (!failed) begin
      $display("tb_checksummed_command_frame_parser_unit OK");
    end else begin
      $display("tb_checksummed_command_frame_parser_unit NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ccfp_pkg.sv
hdl/ccfp_front.sv
hdl/ccfp_queue.sv
hdl/ccfp_back.sv
hdl/checksummed_command_frame_parser_unit.sv
tb/tb_checksummed_command_frame_parser_unit.sv
